>>> hdl/slseq_pkg.sv
// ----------------------------------------------------------------------------
// Status LED sequencer package
// Shared types, codes, reset values and the color walk table.
// ----------------------------------------------------------------------------
`default_nettype none

package slseq_pkg;

   // Number of colors the walk passes through before it wraps (1 to 8).
   localparam int unsigned CYCLE_COLORS = 7;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned CFG_W   = 16;
   localparam int unsigned LEVEL_W = 8;
   localparam int unsigned POS_W   = 3;

   // Event codes.
   localparam logic [2:0] OP_UPDATE       = 3'd0;
   localparam logic [2:0] OP_CONNECT      = 3'd1;
   localparam logic [2:0] OP_DISCONNECT   = 3'd2;
   localparam logic [2:0] OP_MOTION_START = 3'd3;
   localparam logic [2:0] OP_MOTION_STOP  = 3'd4;
   localparam logic [2:0] OP_MANUAL       = 3'd5;

   // LED action codes.
   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_SET   = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // Mode codes.
   localparam logic [1:0] MODE_DISC   = 2'd0;
   localparam logic [1:0] MODE_BURST  = 2'd1;
   localparam logic [1:0] MODE_IDLE   = 2'd2;
   localparam logic [1:0] MODE_MOVING = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] CSR_BURST_LENGTH  = 3'd0;
   localparam logic [2:0] CSR_BURST_STEP    = 3'd1;
   localparam logic [2:0] CSR_IDLE_STEP     = 3'd2;
   localparam logic [2:0] CSR_DISC_BLINK    = 3'd3;
   localparam logic [2:0] CSR_MOVING_BLINK  = 3'd4;
   localparam logic [2:0] CSR_MAN_OFF_HOLD  = 3'd5;
   localparam logic [2:0] CSR_MAN_COLOR_HOLD = 3'd6;

   localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;
   localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 8'd0;

   typedef struct packed {
      logic [CFG_W-1:0] burst_length_ms;
      logic [CFG_W-1:0] burst_step_ms;
      logic [CFG_W-1:0] idle_step_ms;
      logic [CFG_W-1:0] disconnect_blink_ms;
      logic [CFG_W-1:0] moving_blink_ms;
      logic [CFG_W-1:0] manual_off_hold_ms;
      logic [CFG_W-1:0] manual_color_hold_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      burst_length_ms:      16'd3000,
      burst_step_ms:        16'd200,
      idle_step_ms:         16'd1000,
      disconnect_blink_ms:  16'd500,
      moving_blink_ms:      16'd500,
      manual_off_hold_ms:   16'd2000,
      manual_color_hold_ms: 16'd5000
   };

   typedef struct packed {
      logic [1:0]        mode;
      logic              manual_hold;
      logic [TIME_W-1:0] manual_start_time;
      logic [CFG_W-1:0]  manual_hold_length;
      logic [POS_W-1:0]  color_position;
      logic [TIME_W-1:0] last_step_time;
      logic [TIME_W-1:0] connect_time;
      logic [TIME_W-1:0] last_toggle_time;
      logic              blink_phase;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode:               MODE_DISC,
      manual_hold:        1'b0,
      manual_start_time:  '0,
      manual_hold_length: '0,
      color_position:     '0,
      last_step_time:     '0,
      connect_time:       '0,
      last_toggle_time:   '0,
      blink_phase:        1'b1
   };

   typedef struct packed {
      logic [2:0]         operation;
      logic [TIME_W-1:0]  now_ms;
      logic [LEVEL_W-1:0] manual_red;
      logic [LEVEL_W-1:0] manual_green;
      logic [LEVEL_W-1:0] manual_blue;
   } req_type;

   typedef struct packed {
      logic [1:0]         led_action;
      logic [LEVEL_W-1:0] out_red;
      logic [LEVEL_W-1:0] out_green;
      logic [LEVEL_W-1:0] out_blue;
      logic [1:0]         led_mode;
      logic               hold_active;
   } rsp_type;

   // True once at least limit milliseconds have passed since the mark.
   // The subtraction wraps, so timestamp rollover is harmless.
   function automatic logic time_reached(input logic [TIME_W-1:0] now,
                                         input logic [TIME_W-1:0] mark,
                                         input logic [CFG_W-1:0]  limit);
      logic [TIME_W-1:0] delta;
      delta = now - mark;
      return delta >= {{(TIME_W-CFG_W){1'b0}}, limit};
   endfunction

   // Color walk table, {red, green, blue}. The last slot is black.
   function automatic logic [3*LEVEL_W-1:0] walk_color(input logic [POS_W-1:0] pos);
      logic [3*LEVEL_W-1:0] rgb;
      case (pos)
         3'd0:    rgb = {LEVEL_FULL, LEVEL_OFF,  LEVEL_OFF };
         3'd1:    rgb = {LEVEL_OFF,  LEVEL_FULL, LEVEL_OFF };
         3'd2:    rgb = {LEVEL_OFF,  LEVEL_OFF,  LEVEL_FULL};
         3'd3:    rgb = {LEVEL_OFF,  LEVEL_FULL, LEVEL_FULL};
         3'd4:    rgb = {LEVEL_FULL, LEVEL_OFF,  LEVEL_FULL};
         3'd5:    rgb = {LEVEL_FULL, LEVEL_FULL, LEVEL_OFF };
         3'd6:    rgb = {LEVEL_FULL, LEVEL_FULL, LEVEL_FULL};
         default: rgb = {LEVEL_OFF,  LEVEL_OFF,  LEVEL_OFF };
      endcase
      return rgb;
   endfunction

endpackage

`default_nettype wire

>>> hdl/slseq_step.sv
// ----------------------------------------------------------------------------
// Status LED sequencer step logic
// Next state and LED result for one event, given the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module slseq_step (
   input  slseq_pkg::cfg_type   cfg_i,
   input  slseq_pkg::state_type state_i,
   input  slseq_pkg::req_type   req_i,
   output slseq_pkg::state_type state_o,
   output slseq_pkg::rsp_type   rsp_o
);
   import slseq_pkg::*;

   logic [CFG_W-1:0]     blink_half;
   logic [3*LEVEL_W-1:0] blink_rgb;
   logic                 blink_toggle;
   logic                 blink_lit;
   logic [CFG_W-1:0]     step_interval;
   logic                 step_fire;
   logic [3*LEVEL_W-1:0] step_rgb;
   logic [POS_W:0]       pos_inc;
   logic [POS_W-1:0]     pos_next;
   logic                 hold_done;
   logic                 burst_done;
   logic                 manual_black;

   // Shared blink and walk datapaths; the mode picks the interval and color.
   assign blink_half   = (state_i.mode == MODE_DISC) ? cfg_i.disconnect_blink_ms
                                                     : cfg_i.moving_blink_ms;
   assign blink_rgb    = (state_i.mode == MODE_DISC) ?
                         {LEVEL_FULL, LEVEL_OFF, LEVEL_OFF} :
                         {LEVEL_OFF, LEVEL_FULL, LEVEL_OFF};
   assign blink_toggle = time_reached(req_i.now_ms, state_i.last_toggle_time, blink_half);
   assign blink_lit    = state_i.blink_phase ^ blink_toggle;

   assign step_interval = (state_i.mode == MODE_BURST) ? cfg_i.burst_step_ms
                                                       : cfg_i.idle_step_ms;
   assign step_fire     = time_reached(req_i.now_ms, state_i.last_step_time, step_interval);
   assign step_rgb      = walk_color(state_i.color_position);
   assign pos_inc       = {1'b0, state_i.color_position} + (POS_W+1)'(1);
   assign pos_next      = (pos_inc >= (POS_W+1)'(CYCLE_COLORS)) ? '0 : pos_inc[POS_W-1:0];

   assign hold_done  = time_reached(req_i.now_ms, state_i.manual_start_time,
                                    state_i.manual_hold_length);
   assign burst_done = time_reached(req_i.now_ms, state_i.connect_time,
                                    cfg_i.burst_length_ms);
   assign manual_black = (req_i.manual_red == LEVEL_OFF) &&
                         (req_i.manual_green == LEVEL_OFF) &&
                         (req_i.manual_blue == LEVEL_OFF);

   always_comb begin
      state_o = state_i;
      rsp_o   = '0;
      case (req_i.operation)
         OP_UPDATE: begin
            if (state_i.manual_hold) begin
               if (hold_done) begin
                  state_o.manual_hold    = 1'b0;
                  state_o.mode           = MODE_IDLE;
                  state_o.last_step_time = req_i.now_ms;
               end
            end else if (state_i.mode == MODE_BURST && burst_done) begin
               state_o.mode           = MODE_IDLE;
               state_o.last_step_time = req_i.now_ms;
            end else if (state_i.mode == MODE_BURST || state_i.mode == MODE_IDLE) begin
               if (step_fire) begin
                  state_o.last_step_time = req_i.now_ms;
                  state_o.color_position = pos_next;
                  rsp_o.led_action       = ACT_SET;
                  {rsp_o.out_red, rsp_o.out_green, rsp_o.out_blue} = step_rgb;
               end
            end else begin
               if (blink_toggle) begin
                  state_o.last_toggle_time = req_i.now_ms;
               end
               state_o.blink_phase = blink_lit;
               if (blink_lit) begin
                  rsp_o.led_action = ACT_SET;
                  {rsp_o.out_red, rsp_o.out_green, rsp_o.out_blue} = blink_rgb;
               end else begin
                  rsp_o.led_action = ACT_CLEAR;
               end
            end
         end
         OP_CONNECT: begin
            state_o.mode           = MODE_BURST;
            state_o.manual_hold    = 1'b0;
            state_o.color_position = '0;
            state_o.last_step_time = req_i.now_ms;
            state_o.connect_time   = req_i.now_ms;
         end
         OP_DISCONNECT: begin
            state_o.mode             = MODE_DISC;
            state_o.manual_hold      = 1'b0;
            state_o.last_toggle_time = req_i.now_ms;
            state_o.blink_phase      = 1'b1;
            rsp_o.led_action         = ACT_SET;
            rsp_o.out_red            = LEVEL_FULL;
         end
         OP_MOTION_START: begin
            if (!state_i.manual_hold) begin
               state_o.mode             = MODE_MOVING;
               state_o.last_toggle_time = req_i.now_ms;
               state_o.blink_phase      = 1'b1;
               rsp_o.led_action         = ACT_SET;
               rsp_o.out_green          = LEVEL_FULL;
            end
         end
         OP_MOTION_STOP: begin
            if (!state_i.manual_hold && state_i.mode == MODE_MOVING) begin
               state_o.mode           = MODE_IDLE;
               state_o.last_step_time = req_i.now_ms;
            end
         end
         OP_MANUAL: begin
            state_o.manual_hold        = 1'b1;
            state_o.manual_start_time  = req_i.now_ms;
            state_o.manual_hold_length = manual_black ? cfg_i.manual_off_hold_ms
                                                      : cfg_i.manual_color_hold_ms;
            rsp_o.led_action           = ACT_SET;
            rsp_o.out_red              = req_i.manual_red;
            rsp_o.out_green            = req_i.manual_green;
            rsp_o.out_blue             = req_i.manual_blue;
         end
         default: begin
            state_o = state_i;
         end
      endcase
      rsp_o.led_mode    = state_o.mode;
      rsp_o.hold_active = state_o.manual_hold;
   end

endmodule

`default_nettype wire

>>> hdl/status_led_sequencer.sv
// ----------------------------------------------------------------------------
// Status LED sequencer
// RGB status LED mode sequencer driven by timestamped events.
// ----------------------------------------------------------------------------
// Each request transaction carries one event and a millisecond timestamp, and
// produces exactly one response transaction with the LED action, the color,
// the mode after the event and the manual hold flag. The block is a two-stage
// pipeline: a request is captured in an input register, and once the result
// register is empty or being taken the step logic updates the sequencer state
// and loads the result register, from which the response is offered.
// A new request is taken every cycle as long as responses are taken; the
// sustained rate of one transaction per clock is set by the state update,
// which reads the state written by the previous event. Elapsed times
// use wrapping 32-bit subtraction against 16-bit intervals. Configuration
// registers are written through the csr_ port and take effect for the next
// event; they should only be changed while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module status_led_sequencer (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_now_ms,
   input  logic [7:0]  req_manual_red,
   input  logic [7:0]  req_manual_green,
   input  logic [7:0]  req_manual_blue,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_led_action,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic [1:0]  rsp_led_mode,
   output logic        rsp_hold_active
);
   import slseq_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   state_type state_ff, state_in;
   req_type   in_ff;
   logic      in_valid_ff, in_valid_in;
   rsp_type   out_ff, out_in;
   logic      out_valid_ff, out_valid_in;
   logic      advance;

   // The captured event moves into the result register when that register is
   // empty or its transaction is being taken this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Configuration writes; an index beyond the register list is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_BURST_LENGTH:   cfg_in.burst_length_ms      = csr_wdata;
            CSR_BURST_STEP:     cfg_in.burst_step_ms        = csr_wdata;
            CSR_IDLE_STEP:      cfg_in.idle_step_ms         = csr_wdata;
            CSR_DISC_BLINK:     cfg_in.disconnect_blink_ms  = csr_wdata;
            CSR_MOVING_BLINK:   cfg_in.moving_blink_ms      = csr_wdata;
            CSR_MAN_OFF_HOLD:   cfg_in.manual_off_hold_ms   = csr_wdata;
            CSR_MAN_COLOR_HOLD: cfg_in.manual_color_hold_ms = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register stage.
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff.operation    <= req_operation;
         in_ff.now_ms       <= req_now_ms;
         in_ff.manual_red   <= req_manual_red;
         in_ff.manual_green <= req_manual_green;
         in_ff.manual_blue  <= req_manual_blue;
      end
   end

   // Event step: next state and response for the captured event.
   slseq_step u_step (
      .cfg_i   (cfg_ff),
      .state_i (state_ff),
      .req_i   (in_ff),
      .state_o (state_in),
      .rsp_o   (out_in)
   );

   // The state only moves when the event actually advances to the result
   // register, so a stalled event is never applied twice.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register stage.
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_led_action  = out_ff.led_action;
   assign rsp_out_red     = out_ff.out_red;
   assign rsp_out_green   = out_ff.out_green;
   assign rsp_out_blue    = out_ff.out_blue;
   assign rsp_led_mode    = out_ff.led_mode;
   assign rsp_hold_active = out_ff.hold_active;

`ifndef SYNTH
   // The color levels are zero unless the action sets a color.
   a_color_only_on_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_led_action != ACT_SET) |->
         (rsp_out_red == LEVEL_OFF && rsp_out_green == LEVEL_OFF &&
          rsp_out_blue == LEVEL_OFF))
      else $error("color levels set without a set-color action");

   // A manual color event always reports the hold as active.
   a_manual_holds: assert property (@(posedge clock) disable iff (reset)
      (advance && in_ff.operation == OP_MANUAL) |=>
         (rsp_valid && rsp_hold_active && rsp_led_action == ACT_SET))
      else $error("manual color event did not start a hold");

   // A connect event enters the burst mode, cancels any hold and leaves the LED.
   a_connect_burst: assert property (@(posedge clock) disable iff (reset)
      (advance && in_ff.operation == OP_CONNECT) |=>
         (rsp_led_mode == MODE_BURST && !rsp_hold_active &&
          rsp_led_action == ACT_NONE))
      else $error("connect event did not enter burst mode");

   // The reported mode and hold flag track the sequencer state.
   a_rsp_tracks_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_led_mode == state_ff.mode &&
                   rsp_hold_active == state_ff.manual_hold))
      else $error("response mode differs from the sequencer state");
`endif

endmodule

`default_nettype wire

>>> dv/tb_status_led_sequencer.sv
// ----------------------------------------------------------------------------
// Status LED sequencer testbench
// Drives timestamped LED events through the request channel, predicts every
// response with an independent model of the mode sequencer, and compares each
// response field by field under random sender and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_status_led_sequencer;

   import slseq_pkg::*;

   // Half of the clock period.
   localparam int unsigned HALF_PERIOD = 4;

   // Watchdog limit in clock cycles.
   localparam int unsigned CYCLE_LIMIT = 400000;

   // Cycles allowed to pass after the last response before the registers are
   // rewritten or the run ends.
   localparam int unsigned SETTLE_CYCLES = 4;

   localparam logic [15:0] INTERVAL_MIN = 16'd1;
   localparam logic [15:0] INTERVAL_MAX = 16'hFFFF;

   // The register index just past the last defined register.
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   // Codes that the block must treat as no-ops.
   localparam logic [2:0] OP_SPARE_LOW  = 3'd6;
   localparam logic [2:0] OP_SPARE_HIGH = 3'd7;

   logic        clock;
   logic        reset;

   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_operation;
   logic [31:0] req_now_ms;
   logic [7:0]  req_manual_red;
   logic [7:0]  req_manual_green;
   logic [7:0]  req_manual_blue;

   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_led_action;
   logic [7:0]  rsp_out_red;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_blue;
   logic [1:0]  rsp_led_mode;
   logic        rsp_hold_active;

   status_led_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_now_ms       (req_now_ms),
      .req_manual_red   (req_manual_red),
      .req_manual_green (req_manual_green),
      .req_manual_blue  (req_manual_blue),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_led_action   (rsp_led_action),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_led_mode     (rsp_led_mode),
      .rsp_hold_active  (rsp_hold_active)
   );

   // -------------------------------------------------------------------------
   // Shared bookkeeping.
   // -------------------------------------------------------------------------

   // Events waiting to be presented on the request channel.
   req_type     pending_q[$];
   // Predicted responses, oldest first.
   rsp_type     led_due_q[$];

   int unsigned queued_count   = 0;
   int unsigned accepted_count = 0;
   int unsigned due_count      = 0;
   int unsigned fail_count     = 0;
   int unsigned cycle_count    = 0;

   // Percentages of cycles in which each side holds back.
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;

   // Set at each rising edge when a request transaction completed there.
   bit          req_fire = 1'b0;

   // Running millisecond timestamp for generated events.
   logic [31:0] stamp_ms = '0;

   // The predictor's own copy of the registers and of the sequencer state.
   cfg_type     led_cfg;
   state_type   led_st;

   // -------------------------------------------------------------------------
   // Clock and watchdog.
   // -------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever begin
         #HALF_PERIOD clock = ~clock;
      end
   end

   // A hung handshake or a lost response ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Predictor of the sequencer.
   // -------------------------------------------------------------------------

   // Elapsed milliseconds with wrapping subtraction.
   function automatic logic [31:0] since(input logic [31:0] now, input logic [31:0] mark);
      return now - mark;
   endfunction

   // Color walk table as {red, green, blue}; the eighth slot is black.
   function automatic logic [23:0] walk_rgb(input logic [2:0] pos);
      case (pos)
         3'd0:    return 24'hFF0000;
         3'd1:    return 24'h00FF00;
         3'd2:    return 24'h0000FF;
         3'd3:    return 24'h00FFFF;
         3'd4:    return 24'hFF00FF;
         3'd5:    return 24'hFFFF00;
         3'd6:    return 24'hFFFFFF;
         default: return 24'h000000;
      endcase
   endfunction

   function automatic void show_rgb(inout rsp_type r, input logic [23:0] rgb);
      r.led_action = ACT_SET;
      r.out_red    = rgb[23:16];
      r.out_green  = rgb[15:8];
      r.out_blue   = rgb[7:0];
   endfunction

   // One step of a color walk: shows the current slot and moves on once the
   // step interval has passed.
   function automatic void walk_led(inout rsp_type r, input logic [31:0] now,
                                    input logic [15:0] interval);
      int nxt;
      if (since(now, led_st.last_step_time) >= {16'd0, interval}) begin
         led_st.last_step_time = now;
         show_rgb(r, walk_rgb(led_st.color_position));
         nxt = int'(led_st.color_position) + 1;
         if (nxt >= int'(CYCLE_COLORS)) nxt = 0;
         led_st.color_position = nxt[2:0];
      end
   endfunction

   // One step of a blink: toggles after the half period, then shows the lit
   // color or clears the LED.
   function automatic void blink_led(inout rsp_type r, input logic [31:0] now,
                                     input logic [15:0] half, input logic [23:0] rgb);
      if (since(now, led_st.last_toggle_time) >= {16'd0, half}) begin
         led_st.last_toggle_time = now;
         led_st.blink_phase      = ~led_st.blink_phase;
      end
      if (led_st.blink_phase) begin
         show_rgb(r, rgb);
      end else begin
         r.led_action = ACT_CLEAR;
      end
   endfunction

   // Applies one event to the predicted state and returns the response that
   // the block must give for it.
   function automatic rsp_type predict_led(input req_type ev);
      rsp_type r;
      r = '0;
      case (ev.operation)
         OP_UPDATE: begin
            if (led_st.manual_hold) begin
               // On an update a hold ends only once its length has passed; nothing is shown either way.
               if (since(ev.now_ms, led_st.manual_start_time) >=
                   {16'd0, led_st.manual_hold_length}) begin
                  led_st.manual_hold    = 1'b0;
                  led_st.mode           = MODE_IDLE;
                  led_st.last_step_time = ev.now_ms;
               end
            end else begin
               case (led_st.mode)
                  MODE_DISC: blink_led(r, ev.now_ms, led_cfg.disconnect_blink_ms, 24'hFF0000);
                  MODE_BURST: begin
                     if (since(ev.now_ms, led_st.connect_time) >=
                         {16'd0, led_cfg.burst_length_ms}) begin
                        led_st.mode           = MODE_IDLE;
                        led_st.last_step_time = ev.now_ms;
                     end else begin
                        walk_led(r, ev.now_ms, led_cfg.burst_step_ms);
                     end
                  end
                  MODE_IDLE: walk_led(r, ev.now_ms, led_cfg.idle_step_ms);
                  default:   blink_led(r, ev.now_ms, led_cfg.moving_blink_ms, 24'h00FF00);
               endcase
            end
         end
         OP_CONNECT: begin
            led_st.mode           = MODE_BURST;
            led_st.manual_hold    = 1'b0;
            led_st.color_position = '0;
            led_st.last_step_time = ev.now_ms;
            led_st.connect_time   = ev.now_ms;
         end
         OP_DISCONNECT: begin
            led_st.mode             = MODE_DISC;
            led_st.manual_hold      = 1'b0;
            led_st.last_toggle_time = ev.now_ms;
            led_st.blink_phase      = 1'b1;
            show_rgb(r, 24'hFF0000);
         end
         OP_MOTION_START: begin
            if (!led_st.manual_hold) begin
               led_st.mode             = MODE_MOVING;
               led_st.last_toggle_time = ev.now_ms;
               led_st.blink_phase      = 1'b1;
               show_rgb(r, 24'h00FF00);
            end
         end
         OP_MOTION_STOP: begin
            if (!led_st.manual_hold && led_st.mode == MODE_MOVING) begin
               led_st.mode           = MODE_IDLE;
               led_st.last_step_time = ev.now_ms;
            end
         end
         OP_MANUAL: begin
            led_st.manual_hold       = 1'b1;
            led_st.manual_start_time = ev.now_ms;
            if (ev.manual_red == 8'd0 && ev.manual_green == 8'd0 && ev.manual_blue == 8'd0)
               led_st.manual_hold_length = led_cfg.manual_off_hold_ms;
            else
               led_st.manual_hold_length = led_cfg.manual_color_hold_ms;
            show_rgb(r, {ev.manual_red, ev.manual_green, ev.manual_blue});
         end
         default: begin
            // Spare codes leave everything as it is.
         end
      endcase
      r.led_mode    = led_st.mode;
      r.hold_active = led_st.manual_hold;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Request driver. Payloads change only at the falling edge; a presented
   // transaction is held until it has been accepted.
   // -------------------------------------------------------------------------

   initial begin
      req_type next_ev;
      req_valid        = 1'b0;
      req_operation    = '0;
      req_now_ms       = '0;
      req_manual_red   = '0;
      req_manual_green = '0;
      req_manual_blue  = '0;
      forever begin
         @(negedge clock);
         if (req_valid && !req_fire) begin
            // Still waiting for the block to take the current transaction.
         end else if (pending_q.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            next_ev           = pending_q.pop_front();
            req_valid        <= 1'b1;
            req_operation    <= next_ev.operation;
            req_now_ms       <= next_ev.now_ms;
            req_manual_red   <= next_ev.manual_red;
            req_manual_green <= next_ev.manual_green;
            req_manual_blue  <= next_ev.manual_blue;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The receiver stalls at random, decided once per cycle.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Monitor and scoreboard. Everything is sampled at the rising edge. An
   // accepted request is turned into a prediction right away, so its entry is
   // queued before the matching response can possibly show up.
   // -------------------------------------------------------------------------

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      req_type ev;
      rsp_type want;
      cycle_count++;
      req_fire = !reset && req_valid && req_ready;
      if (req_fire) begin
         ev.operation    = req_operation;
         ev.now_ms       = req_now_ms;
         ev.manual_red   = req_manual_red;
         ev.manual_green = req_manual_green;
         ev.manual_blue  = req_manual_blue;
         led_due_q.push_back(predict_led(ev));
         due_count++;
         accepted_count++;
      end
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (due_count == 0) begin
            $error("response transaction with no event outstanding");
            fail_count++;
         end else begin
            want = led_due_q.pop_front();
            due_count--;
            check_field("led_action",  32'(want.led_action),  32'(rsp_led_action));
            check_field("out_red",     32'(want.out_red),     32'(rsp_out_red));
            check_field("out_green",   32'(want.out_green),   32'(rsp_out_green));
            check_field("out_blue",    32'(want.out_blue),    32'(rsp_out_blue));
            check_field("led_mode",    32'(want.led_mode),    32'(rsp_led_mode));
            check_field("hold_active", 32'(want.hold_active), 32'(rsp_hold_active));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Shared stimulus tasks.
   // -------------------------------------------------------------------------

   // Queues one event and returns once the block has accepted it.
   task automatic send_event(input logic [2:0] op, input logic [31:0] now,
                             input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue);
      req_type     ev;
      int unsigned ticket;
      ev.operation    = op;
      ev.now_ms       = now;
      ev.manual_red   = red;
      ev.manual_green = green;
      ev.manual_blue  = blue;
      ticket = queued_count;
      queued_count++;
      pending_q.push_back(ev);
      wait (accepted_count > ticket);
   endtask

   // Sends an event at the running timestamp after moving it forward.
   task automatic send_at(input logic [2:0] op, input logic [31:0] delta);
      stamp_ms = stamp_ms + delta;
      send_event(op, stamp_ms, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
   endtask

   // Holds the sender back until every outstanding response has arrived.
   task automatic wait_for_results();
      wait (accepted_count == queued_count && due_count == 0);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      case (idx)
         CSR_BURST_LENGTH:   led_cfg.burst_length_ms      = value;
         CSR_BURST_STEP:     led_cfg.burst_step_ms        = value;
         CSR_IDLE_STEP:      led_cfg.idle_step_ms         = value;
         CSR_DISC_BLINK:     led_cfg.disconnect_blink_ms  = value;
         CSR_MOVING_BLINK:   led_cfg.moving_blink_ms      = value;
         CSR_MAN_OFF_HOLD:   led_cfg.manual_off_hold_ms   = value;
         CSR_MAN_COLOR_HOLD: led_cfg.manual_color_hold_ms = value;
         default: begin
            // Writes past the last register are dropped by the block.
         end
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Rewrites all registers once the block has gone quiet.
   task automatic load_settings(input cfg_type c);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(CSR_BURST_LENGTH,   c.burst_length_ms);
      write_csr(CSR_BURST_STEP,     c.burst_step_ms);
      write_csr(CSR_IDLE_STEP,      c.idle_step_ms);
      write_csr(CSR_DISC_BLINK,     c.disconnect_blink_ms);
      write_csr(CSR_MOVING_BLINK,   c.moving_blink_ms);
      write_csr(CSR_MAN_OFF_HOLD,   c.manual_off_hold_ms);
      write_csr(CSR_MAN_COLOR_HOLD, c.manual_color_hold_ms);
   endtask

   // An interval setting: the extremes, short ones, or anything in range.
   function automatic logic [15:0] pick_interval();
      case ($urandom_range(3))
         0:       return INTERVAL_MIN;
         1:       return INTERVAL_MAX;
         2:       return 16'($urandom_range(1, 40));
         default: return 16'($urandom_range(1, 65535));
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      c.burst_length_ms      = pick_interval();
      c.burst_step_ms        = pick_interval();
      c.idle_step_ms         = pick_interval();
      c.disconnect_blink_ms  = pick_interval();
      c.moving_blink_ms      = pick_interval();
      c.manual_off_hold_ms   = pick_interval();
      c.manual_color_hold_ms = pick_interval();
      return c;
   endfunction

   // A timestamp step sized around the interval that matters next, so that
   // the compare lands right at, just short of, and well past its threshold.
   function automatic logic [31:0] next_delta(input logic [15:0] span);
      case ($urandom_range(5))
         0:       return 32'd0;
         1:       return {16'd0, span};
         2:       return {16'd0, span} - 32'd1;
         3:       return $urandom_range(0, 2 * int'(span));
         4:       return $urandom_range(0, int'(span) / 2);
         default: return $urandom_range(1, 3);
      endcase
   endfunction

   // One random scenario. Most are well-formed mode sequences with random
   // timing; the rest are noise on all fields.
   task automatic play_scenario();
      int unsigned n;
      logic [31:0] mark;
      logic [15:0] hold;
      logic [7:0]  red, green, blue;
      case ($urandom_range(7))
         0: stamp_ms = $urandom();
         1: stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
         default: ;
      endcase
      n = $urandom_range(2, 10);
      case ($urandom_range(9))
         0, 1: begin
            // Connect burst that usually runs out into the idle walk.
            send_at(OP_CONNECT, 32'd0);
            mark = stamp_ms;
            repeat (n) send_at(OP_UPDATE, next_delta(led_cfg.burst_step_ms));
            if ($urandom_range(1)) begin
               stamp_ms = mark + led_cfg.burst_length_ms - $urandom_range(0, 1);
               send_at(OP_UPDATE, 32'd0);
               send_at(OP_UPDATE, $urandom_range(0, 1));
            end
            repeat ($urandom_range(1, 4)) send_at(OP_UPDATE, next_delta(led_cfg.idle_step_ms));
         end
         2: begin
            send_at(OP_DISCONNECT, 32'd0);
            repeat (n) send_at(OP_UPDATE, next_delta(led_cfg.disconnect_blink_ms));
         end
         3, 4: begin
            send_at(OP_MOTION_START, 32'd0);
            repeat (n) send_at(OP_UPDATE, next_delta(led_cfg.moving_blink_ms));
            if ($urandom_range(9) < 7) begin
               send_at(OP_MOTION_STOP, next_delta(led_cfg.moving_blink_ms));
               repeat ($urandom_range(1, 5))
                  send_at(OP_UPDATE, next_delta(led_cfg.idle_step_ms));
            end
         end
         5, 6: begin
            // Manual color hold, with motion noise that must be ignored.
            if ($urandom_range(3) == 0) begin
               red = 8'd0; green = 8'd0; blue = 8'd0;
               hold = led_cfg.manual_off_hold_ms;
            end else begin
               red   = 8'($urandom_range(0, 255));
               green = 8'($urandom_range(0, 255));
               blue  = 8'($urandom_range(0, 255));
               hold  = led_cfg.manual_color_hold_ms;
            end
            send_event(OP_MANUAL, stamp_ms, red, green, blue);
            mark = stamp_ms;
            repeat (n) begin
               case ($urandom_range(4))
                  0:       send_at(OP_MOTION_START, next_delta(hold));
                  1:       send_at(OP_MOTION_STOP, next_delta(hold));
                  default: send_at(OP_UPDATE, next_delta(hold));
               endcase
            end
            if ($urandom_range(1)) begin
               stamp_ms = mark + hold - 32'd1;
               send_at(OP_UPDATE, 32'd0);
               send_at(OP_UPDATE, 32'd1);
               repeat ($urandom_range(1, 3))
                  send_at(OP_UPDATE, next_delta(led_cfg.idle_step_ms));
            end
         end
         7: begin
            repeat (n) begin
               if ($urandom_range(4) == 0) send_at(OP_MOTION_STOP, 32'd1);
               else send_at(OP_UPDATE, next_delta(led_cfg.idle_step_ms));
            end
         end
         8: begin
            repeat ($urandom_range(1, 4))
               send_event(3'($urandom_range(0, 7)), $urandom(), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end
         default: begin
            // Let the pipeline run completely dry before going on.
            wait_for_results();
            send_at(OP_UPDATE, next_delta(led_cfg.idle_step_ms));
         end
      endcase
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned target;
      target = queued_count + count;
      while (queued_count < target) play_scenario();
   endtask

   // -------------------------------------------------------------------------
   // Tests.
   // -------------------------------------------------------------------------

   // Walks every event and every mode at the reset settings, including the
   // timestamp wrap, the end of the burst, holds being released by time and
   // cancelled by connect or disconnect, and the spare operation codes.
   task automatic test_directed_modes();
      send_event(OP_UPDATE,       32'd0,        8'd0, 8'd0, 8'd0);
      send_event(OP_UPDATE,       32'd499,      8'd0, 8'd0, 8'd0);
      send_event(OP_UPDATE,       32'd500,      8'd0, 8'd0, 8'd0);
      send_event(OP_DISCONNECT,   32'hFFFF_FF00, 8'd0, 8'd0, 8'd0);
      send_event(OP_UPDATE,       32'h0000_00F4, 8'd0, 8'd0, 8'd0);
      send_event(OP_UPDATE,       32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0);
      send_event(OP_CONNECT,      32'd1000,     8'd0, 8'd0, 8'd0);
      // Seven burst steps cover the whole color walk, the eighth wraps it.
      for (int i = 1; i <= 8; i++)
         send_event(OP_UPDATE, 32'd1000 + 32'd200 * i, 8'd0, 8'd0, 8'd0);
      send_event(OP_UPDATE,       32'd4000,     8'd0, 8'd0, 8'd0);
      send_event(OP_UPDATE,       32'd5000,     8'd0, 8'd0, 8'd0);
      send_event(OP_MOTION_START, 32'd6000,     8'd0, 8'd0, 8'd0);
      send_event(OP_UPDATE,       32'd6500,     8'd0, 8'd0, 8'd0);
      send_event(OP_MOTION_STOP,  32'd6600,     8'd0, 8'd0, 8'd0);
      // An all-black manual color uses the short hold.
      send_event(OP_MANUAL,       32'd7000,     8'd0, 8'd0, 8'd0);
      send_event(OP_MOTION_START, 32'd7100,     8'd0, 8'd0, 8'd0);
      send_event(OP_UPDATE,       32'd8999,     8'd0, 8'd0, 8'd0);
      send_event(OP_UPDATE,       32'd9000,     8'd0, 8'd0, 8'd0);
      send_event(OP_MANUAL,       32'd9100,     8'hFF, 8'hFF, 8'hFF);
      send_event(OP_CONNECT,      32'd9200,     8'd0, 8'd0, 8'd0);
      send_event(OP_MANUAL,       32'd9300,     8'hA5, 8'h5A, 8'h01);
      send_event(OP_DISCONNECT,   32'd9400,     8'd0, 8'd0, 8'd0);
      send_event(OP_SPARE_LOW,    32'd9500,     8'h5A, 8'hA5, 8'hFE);
      send_event(OP_SPARE_HIGH,   32'd9600,     8'hFF, 8'hFF, 8'hFF);
   endtask

   // Every interval at one millisecond: nearly every update fires.
   task automatic test_minimum_intervals();
      cfg_type c;
      c = '{default: INTERVAL_MIN};
      load_settings(c);
      run_random(100);
   endtask

   // Every interval at its maximum, plus a write to the unused index that
   // must not disturb any register.
   task automatic test_maximum_intervals();
      cfg_type c;
      c = '{default: INTERVAL_MAX};
      load_settings(c);
      write_csr(CSR_UNUSED, 16'h0001);
      run_random(150);
   endtask

   task automatic test_mixed_settings(input int unsigned rounds, input int unsigned count);
      repeat (rounds) begin
         load_settings(random_settings());
         run_random(count);
      end
   endtask

   // Back to the reset values, written explicitly this time.
   task automatic test_reset_settings();
      load_settings(CFG_RESET);
      run_random(100);
   endtask

   // -------------------------------------------------------------------------
   // Sequence of the run.
   // -------------------------------------------------------------------------

   initial begin
      led_cfg      = CFG_RESET;
      led_st       = STATE_RESET;
      reset        = 1'b1;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Sender idles rarely, receiver most of the time.
      req_idle_pct = 11;
      rsp_idle_pct = 62;
      test_directed_modes();
      wait_for_results();
      test_minimum_intervals();
      test_maximum_intervals();

      // The other way round.
      req_idle_pct = 62;
      rsp_idle_pct = 11;
      test_mixed_settings(3, 100);

      // Full rate on both sides.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_mixed_settings(1, 200);
      test_reset_settings();

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && due_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
